// File: src/bmm_pkg.sv
// Shared constants, codes and width helpers for the Barrett modular multiplier.
`timescale 1ns / 1ps
package bmm_pkg;

    localparam int LIMB_W        = 32;
    localparam int WORD_W        = 64;
    localparam int MOD_WIDTH_DEF = 128;
    localparam int MU_W          = 130;
    localparam int NBITS_W       = 8;
    localparam int CMD_W         = 2;
    localparam int CFG_IDX_W     = 3;
    localparam int MU_TOP_W      = 2;

    localparam logic [NBITS_W-1:0] NBITS_RESET = 8'd128;

    // command codes; bit 1 set means subtract
    localparam logic [CMD_W-1:0] CMD_MUL     = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SQR     = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SUB     = 2'd2;
    localparam int               CMD_SUB_BIT = 1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_NBITS  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_P_LO   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_P_HI   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MU_LO  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MU_HI  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MU_TOP = 3'd5;

    // stages of a limb multiplier: partial products, then a registered adder tree
    function automatic int mul_lat(input int aw);
        return 1 + $clog2(2 * ((aw + LIMB_W - 1) / LIMB_W));
    endfunction

    // full product width of a limb multiplier
    function automatic int mul_pw(input int aw, input int bw);
        return ((aw + LIMB_W - 1) / LIMB_W + (bw + LIMB_W - 1) / LIMB_W) * LIMB_W;
    endfunction

endpackage

// File: src/bmm_in_if.sv
// Operation channel: command and two operands.
`timescale 1ns / 1ps
interface bmm_in_if;
    logic                        valid;
    logic                        ready;
    logic [bmm_pkg::CMD_W-1:0]   cmd;
    logic [bmm_pkg::WORD_W-1:0]  a_low;
    logic [bmm_pkg::WORD_W-1:0]  a_high;
    logic [bmm_pkg::WORD_W-1:0]  b_low;
    logic [bmm_pkg::WORD_W-1:0]  b_high;

    modport source (output valid, cmd, a_low, a_high, b_low, b_high, input ready);
    modport sink   (input valid, cmd, a_low, a_high, b_low, b_high, output ready);
endinterface

// File: src/bmm_out_if.sv
// Result channel: reduced field element.
`timescale 1ns / 1ps
interface bmm_out_if;
    logic                        valid;
    logic                        ready;
    logic [bmm_pkg::WORD_W-1:0]  result_low;
    logic [bmm_pkg::WORD_W-1:0]  result_high;

    modport source (output valid, result_low, result_high, input ready);
    modport sink   (input valid, result_low, result_high, output ready);
endinterface

// File: src/barrett_modular_multiply_core.sv
// Top level: prime-field multiply, square and subtract with Barrett reduction.
//
//  port      | dir | kind          | payload
//  i_in      | in  | valid/ready   | cmd, a_low, a_high, b_low, b_high
//  o_out     | out | valid/ready   | result_low, result_high
//  i_cfg_*   | in  | write only    | modulus_bits, prime, mu by index
//
// One item per cycle while o_out is not stalled. The pipeline holds three chained limb
// multipliers (x = a*b, (x >> n) * mu, q * p), each a partial-product stage and
// an adder tree.
// Synchronous reset clears the valid bits and loads the register reset values.
// A stall holds only the stages that are full; bubbles still drain forward.
`timescale 1ns / 1ps
module barrett_modular_multiply_core #(
    parameter int MOD_WIDTH = bmm_pkg::MOD_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [bmm_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [bmm_pkg::WORD_W-1:0]      i_cfg_data,
    bmm_in_if.sink                          i_in,
    bmm_out_if.source                       o_out
);
    localparam int W    = MOD_WIDTH;
    localparam int RW   = W + 2;
    localparam int NW   = bmm_pkg::NBITS_W;
    localparam int WW   = bmm_pkg::WORD_W;
    localparam int OW   = 2 * WW;
    localparam int MU_W = bmm_pkg::MU_W;

    localparam int L1 = bmm_pkg::mul_lat(W);
    localparam int L2 = bmm_pkg::mul_lat(W);
    localparam int L3 = bmm_pkg::mul_lat(W);
    localparam int XW = bmm_pkg::mul_pw(W, W);
    localparam int TW = bmm_pkg::mul_pw(W, MU_W);
    localparam int QW = bmm_pkg::mul_pw(W, RW);

    localparam int S_IN  = 0;
    localparam int S_M1  = S_IN + 1;
    localparam int S_XH  = S_M1 + L1;
    localparam int S_M2  = S_XH + 1;
    localparam int S_Q   = S_M2 + L2;
    localparam int S_M3  = S_Q + 1;
    localparam int S_R   = S_M3 + L3;
    localparam int S_OUT = S_R + 1;
    localparam int NS    = S_OUT + 1;
    localparam int D_XL  = S_R - 1 - S_XH;

    // configuration registers
    logic [NW-1:0]                 r_nbits;
    logic [WW-1:0]                 r_p_lo, r_p_hi, r_mu_lo, r_mu_hi;
    logic [bmm_pkg::MU_TOP_W-1:0]  r_mu_top;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nbits  <= bmm_pkg::NBITS_RESET;
            r_p_lo   <= '0;
            r_p_hi   <= '0;
            r_mu_lo  <= '0;
            r_mu_hi  <= '0;
            r_mu_top <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                bmm_pkg::CFG_NBITS:  r_nbits  <= i_cfg_data[NW-1:0];
                bmm_pkg::CFG_P_LO:   r_p_lo   <= i_cfg_data;
                bmm_pkg::CFG_P_HI:   r_p_hi   <= i_cfg_data;
                bmm_pkg::CFG_MU_LO:  r_mu_lo  <= i_cfg_data;
                bmm_pkg::CFG_MU_HI:  r_mu_hi  <= i_cfg_data;
                bmm_pkg::CFG_MU_TOP: r_mu_top <= i_cfg_data[bmm_pkg::MU_TOP_W-1:0];
                default: ;
            endcase
        end
    end

    logic [NW-1:0]   n_eff;
    logic [NW:0]     n_r;
    logic [W-1:0]    mask_n;
    logic [RW-1:0]   mask_r;
    logic [OW-1:0]   p_cat;
    logic [W-1:0]    p;
    logic [MU_W-1:0] mu;

    // n saturates to 2..MOD_WIDTH
    always_comb begin
        if (r_nbits < NW'(2))      n_eff = NW'(2);
        else if (r_nbits > NW'(W)) n_eff = NW'(W);
        else                       n_eff = r_nbits;
        n_r = {1'b0, n_eff} + (NW+1)'(2);
        for (int i = 0; i < W; i++)  mask_n[i] = (NW+1)'(i) < {1'b0, n_eff};
        for (int i = 0; i < RW; i++) mask_r[i] = (NW+1)'(i) < n_r;
    end

    assign p_cat = {r_p_hi, r_p_lo};
    assign p     = p_cat[W-1:0];
    assign mu    = {r_mu_top, r_mu_hi, r_mu_lo};

    // stage enables: a stage moves when empty or when the next one moves
    logic [NS:0]   en;
    logic [NS-1:0] r_vld;

    always_comb begin
        en[NS] = o_out.ready;
        for (int k = NS - 1; k >= 0; k--) en[k] = !r_vld[k] || en[k+1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) r_vld[0] <= i_in.valid;
            for (int k = 1; k < NS; k++) begin
                if (en[k]) r_vld[k] <= r_vld[k-1];
            end
        end
    end

    assign i_in.ready  = en[0];
    assign o_out.valid = r_vld[NS-1];

    // input stage
    logic [OW-1:0] a_cat, b_cat;
    logic [W-1:0]  in_a, in_b;
    logic [W-1:0]  r_s0_a, r_s0_b;
    logic          r_s0_sub;

    assign a_cat = {i_in.a_high, i_in.a_low};
    assign b_cat = {i_in.b_high, i_in.b_low};
    assign in_a  = a_cat[W-1:0] & mask_n;
    assign in_b  = ((i_in.cmd == bmm_pkg::CMD_SQR) ? a_cat[W-1:0] : b_cat[W-1:0]) & mask_n;

    always_ff @(posedge i_clk) begin
        if (en[S_IN]) begin
            r_s0_a   <= in_a;
            r_s0_b   <= in_b;
            r_s0_sub <= i_in.cmd[bmm_pkg::CMD_SUB_BIT];
        end
    end

    // subtract path: add p back on borrow, keep n bits
    logic [W:0]   diff;
    logic [W-1:0] sub_res;
    logic [W:0]   side_d;

    assign diff    = {1'b0, r_s0_a} - {1'b0, r_s0_b};
    assign sub_res = (diff[W-1:0] + (diff[W] ? p : '0)) & mask_n;

    bmm_dly #(.W(W + 1), .D(S_R)) u_side (
        .i_clk (i_clk),
        .i_en  (en[S_IN+1 +: S_R]),
        .i_d   ({r_s0_sub, sub_res}),
        .o_q   (side_d)
    );

    // x = a * b
    logic [XW-1:0] x, xsh;
    logic [W-1:0]  r_xh;
    logic [RW-1:0] r_xl, xl_d;

    bmm_mul #(.AW(W), .BW(W)) u_mul_x (
        .i_clk (i_clk),
        .i_en  (en[S_M1 +: L1]),
        .i_a   (r_s0_a),
        .i_b   (r_s0_b),
        .o_p   (x)
    );

    assign xsh = x >> n_eff;

    always_ff @(posedge i_clk) begin
        if (en[S_XH]) begin
            r_xh <= xsh[W-1:0];
            r_xl <= x[RW-1:0];
        end
    end

    bmm_dly #(.W(RW), .D(D_XL)) u_xl (
        .i_clk (i_clk),
        .i_en  (en[S_XH+1 +: D_XL]),
        .i_d   (r_xl),
        .o_q   (xl_d)
    );

    // q = ((x >> n) * mu) >> n, low n+2 bits are all that matter downstream
    logic [TW-1:0] t, tsh;
    logic [RW-1:0] r_q;

    bmm_mul #(.AW(W), .BW(MU_W)) u_mul_t (
        .i_clk (i_clk),
        .i_en  (en[S_M2 +: L2]),
        .i_a   (r_xh),
        .i_b   (mu),
        .o_p   (t)
    );

    assign tsh = t >> n_eff;

    always_ff @(posedge i_clk) begin
        if (en[S_Q]) r_q <= tsh[RW-1:0];
    end

    // q * p
    logic [QW-1:0] qp;
    logic [RW-1:0] r_r;

    bmm_mul #(.AW(W), .BW(RW)) u_mul_qp (
        .i_clk (i_clk),
        .i_en  (en[S_M3 +: L3]),
        .i_a   (p),
        .i_b   (r_q),
        .o_p   (qp)
    );

    always_ff @(posedge i_clk) begin
        if (en[S_R]) r_r <= (xl_d - qp[RW-1:0]) & mask_r;
    end

    // final correction: take off 2p or p where r reaches it; subtract results bypass it
    logic [RW-1:0] p1, p2, red, fin;
    logic [RW-1:0] r_out;

    assign p1 = {2'b00, p};
    assign p2 = {1'b0, p, 1'b0};

    always_comb begin
        if (r_r >= p2)      red = r_r - p2;
        else if (r_r >= p1) red = r_r - p1;
        else                red = r_r;
        fin = side_d[W] ? {2'b00, side_d[W-1:0]} : (red & mask_r);
    end

    always_ff @(posedge i_clk) begin
        if (en[S_OUT]) r_out <= fin;
    end

    logic [OW-1:0] res;

    if (RW >= OW) begin : g_res_trunc
        assign res = r_out[OW-1:0];
    end else begin : g_res_ext
        assign res = {{(OW - RW){1'b0}}, r_out};
    end

    assign o_out.result_low  = res[WW-1:0];
    assign o_out.result_high = res[OW-1:WW];
endmodule

// File: src/bmm_mul.sv
// Pipelined limb multiplier: 32x32 partial products and a registered adder tree.
`timescale 1ns / 1ps
module bmm_mul #(
    parameter int AW = 128,
    parameter int BW = 128,
    localparam int NA  = (AW + bmm_pkg::LIMB_W - 1) / bmm_pkg::LIMB_W,
    localparam int NB  = (BW + bmm_pkg::LIMB_W - 1) / bmm_pkg::LIMB_W,
    localparam int PW  = bmm_pkg::mul_pw(AW, BW),
    localparam int LAT = bmm_pkg::mul_lat(AW)
) (
    input  logic           i_clk,
    input  logic [LAT-1:0] i_en,
    input  logic [AW-1:0]  i_a,
    input  logic [BW-1:0]  i_b,
    output logic [PW-1:0]  o_p
);
    localparam int LW   = bmm_pkg::LIMB_W;
    localparam int NOPS = 1 << (LAT - 1);

    logic [NA*LW-1:0] a_pad;
    logic [NB*LW-1:0] b_pad;
    logic [2*LW-1:0]  r_pp [NA][NB];
    logic [PW-1:0]    ops [NOPS];
    logic [PW-1:0]    node [1:2*NOPS-1];
    logic [PW-1:0]    r_node [1:NOPS-1];

    assign a_pad = (NA*LW)'(i_a);
    assign b_pad = (NB*LW)'(i_b);

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            for (int i = 0; i < NA; i++) begin
                for (int j = 0; j < NB; j++) begin
                    r_pp[i][j] <= {{LW{1'b0}}, a_pad[i*LW +: LW]}
                                * {{LW{1'b0}}, b_pad[j*LW +: LW]};
                end
            end
        end
    end

    // even and odd columns of a row never overlap, so each row packs into two words
    always_comb begin
        for (int k = 0; k < NOPS; k++) ops[k] = '0;
        for (int i = 0; i < NA; i++) begin
            for (int j = 0; j < NB; j++) begin
                ops[2*i + (j % 2)][(i + j) * LW +: 2 * LW] = r_pp[i][j];
            end
        end
    end

    always_comb begin
        for (int k = 1; k < NOPS; k++) node[k] = r_node[k];
        for (int k = 0; k < NOPS; k++) node[NOPS + k] = ops[k];
    end

    for (genvar k = 1; k < NOPS; k++) begin : g_node
        localparam int D = $clog2(k + 1) - 1;
        always_ff @(posedge i_clk) begin
            if (i_en[LAT - 1 - D]) begin
                r_node[k] <= node[2*k] + node[2*k + 1];
            end
        end
    end

    assign o_p = r_node[1];
endmodule

// File: src/bmm_dly.sv
// Side-band delay line that moves in step with the pipeline stages it spans.
`timescale 1ns / 1ps
module bmm_dly #(
    parameter int W = 8,
    parameter int D = 1
) (
    input  logic         i_clk,
    input  logic [D-1:0] i_en,
    input  logic [W-1:0] i_d,
    output logic [W-1:0] o_q
);
    logic [W-1:0] r_sr [D];

    always_ff @(posedge i_clk) begin
        if (i_en[0]) r_sr[0] <= i_d;
        for (int k = 1; k < D; k++) begin
            if (i_en[k]) r_sr[k] <= r_sr[k-1];
        end
    end

    assign o_q = r_sr[D-1];
endmodule

// File: src/bmm_chk.sv
// Port-level checks for the Barrett modular multiplier, bound to the top level.
`timescale 1ns / 1ps
module bmm_chk (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_ready,
    input logic                         i_out_valid,
    input logic                         i_out_ready,
    input logic [bmm_pkg::WORD_W-1:0]   i_res_low,
    input logic [bmm_pkg::WORD_W-1:0]   i_res_high
);
    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_res_low)
                                        && $stable(i_res_high))
        else $error("result changed during stall");

    // reset empties the pipeline
    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    // a consumer that takes results never blocks the input
    a_ready_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_ready |-> i_in_ready)
        else $error("input stalled while output drains");

    // empty output stage means the chain can shift
    a_empty_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled with empty output stage");
endmodule

bind barrett_modular_multiply_core bmm_chk u_bmm_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_res_low   (o_out.result_low),
    .i_res_high  (o_out.result_high)
);

// File: verif/barrett_modular_multiply_core_tb.sv
// Testbench for the Barrett modular multiply core: directed table, then random traffic.
`timescale 1ns / 1ps
module barrett_modular_multiply_core_tb;

    localparam int LAT = 17;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef logic [383:0] t_wide;

    typedef struct {
        logic [bmm_pkg::CMD_W-1:0]  cmd;
        logic [127:0]               a;
        logic [127:0]               b;
        bit                         has_exp;
        logic [127:0]               exp;
    } t_op_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [bmm_pkg::CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [bmm_pkg::WORD_W-1:0] i_cfg_data = '0;

    bmm_in_if  op_ch ();
    bmm_out_if res_ch ();

    barrett_modular_multiply_core u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (op_ch.sink),
        .o_out      (res_ch.source)
    );

    always #1 i_clk = ~i_clk;

    // shadow registers
    logic [7:0]   sh_nbits;
    logic [127:0] sh_prime;
    logic [129:0] sh_mu;

    logic [127:0] result_q[$];
    int  mismatches = 0;
    int  idle_cycles = 0;
    bit  rx_hold = 1'b0;

    function automatic t_wide lowmask(input int bits);
        t_wide m;
        m = '0;
        for (int i = 0; i < bits; i++) m[i] = 1'b1;
        return m;
    endfunction

    function automatic logic [127:0] field_op(input logic [bmm_pkg::CMD_W-1:0] cmd,
                                              input logic [127:0] a_in,
                                              input logic [127:0] b_in);
        int n;
        t_wide a, b, p, x, r, q, mu, p2, nm;
        n = int'(sh_nbits);
        if (n < 2) n = 2;
        if (n > 128) n = 128;
        nm = lowmask(n);
        a = t_wide'(a_in) & nm;
        b = t_wide'(b_in) & nm;
        p = t_wide'(sh_prime);
        mu = t_wide'(sh_mu);
        if (cmd[bmm_pkg::CMD_SUB_BIT]) begin
            r = a - b;
            if (a < b) r = r + p;
            r = r & nm;
        end else begin
            x = a * ((cmd == bmm_pkg::CMD_SQR) ? a : b);
            q = (((x >> n) * mu) & lowmask(320)) >> n;
            r = (x - ((q * p) & lowmask(320))) & lowmask(n + 2);
            p2 = p + p;
            if (r >= p2) r = r - p2;
            else if (r >= p) r = r - p;
            r = r & lowmask(n + 2);
        end
        return r[127:0];
    endfunction

    task automatic cfg_write(input logic [bmm_pkg::CFG_IDX_W-1:0] idx,
                             input logic [63:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        @(posedge i_clk);
        case (idx)
            bmm_pkg::CFG_NBITS:  sh_nbits = val[7:0];
            bmm_pkg::CFG_P_LO:   sh_prime[63:0] = val;
            bmm_pkg::CFG_P_HI:   sh_prime[127:64] = val;
            bmm_pkg::CFG_MU_LO:  sh_mu[63:0] = val;
            bmm_pkg::CFG_MU_HI:  sh_mu[127:64] = val;
            bmm_pkg::CFG_MU_TOP: sh_mu[129:128] = val[1:0];
            default: ;
        endcase
    endtask

    // loads n, p and mu = floor(4^n/p)
    task automatic set_field(input int n, input logic [127:0] p);
        logic [259:0] four_n;
        logic [259:0] m;
        four_n = 260'd1 << (2 * n);
        m = four_n / {132'd0, p};
        cfg_write(bmm_pkg::CFG_NBITS, 64'(n));
        cfg_write(bmm_pkg::CFG_P_LO, p[63:0]);
        cfg_write(bmm_pkg::CFG_P_HI, p[127:64]);
        cfg_write(bmm_pkg::CFG_MU_LO, m[63:0]);
        cfg_write(bmm_pkg::CFG_MU_HI, m[127:64]);
        cfg_write(bmm_pkg::CFG_MU_TOP, 64'(m[129:128]));
    endtask

    // the last item leaves valid high; drop it here, then wait for every result
    task automatic drain();
        op_ch.valid <= 1'b0;
        while (result_q.size() != 0) @(posedge i_clk);
        repeat (LAT + 4) @(posedge i_clk);
    endtask

    // valid stays high after a transfer so the next item can follow without a gap
    task automatic send_op(input logic [bmm_pkg::CMD_W-1:0] cmd, input logic [127:0] a,
                           input logic [127:0] b, input bit gaps);
        int gap;
        gap = gaps ? $urandom_range(0, 17) : 0;
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            op_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        op_ch.valid  <= 1'b1;
        op_ch.cmd    <= cmd;
        op_ch.a_low  <= a[63:0];
        op_ch.a_high <= a[127:64];
        op_ch.b_low  <= b[63:0];
        op_ch.b_high <= b[127:64];
        @(posedge i_clk);
        while (!op_ch.ready) @(posedge i_clk);
        result_q.push_back(field_op(cmd, a, b));
    endtask

    function automatic logic [127:0] rand128();
        return {$urandom, $urandom, $urandom, $urandom};
    endfunction

    function automatic logic [127:0] below_p();
        logic [127:0] v;
        case ($urandom_range(0, 5))
            0: v = 0;
            1: v = sh_prime - 1;
            2: v = 1;
            default: v = rand128() % sh_prime;
        endcase
        if ($urandom_range(0, 20) == 0) v = rand128(); // wide operand
        return v;
    endfunction

    // result side: random stalls, checks against oldest expectation
    initial begin
        int wait_n;
        res_ch.ready = 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            wait_n = $urandom_range(0, 17);
            if ($urandom_range(0, 2) == 0) wait_n = 0;
            if (rx_hold) wait_n = 0;
            if (wait_n > 0 || rx_hold) begin
                res_ch.ready <= 1'b0;
                repeat (wait_n) @(posedge i_clk);
                while (rx_hold) @(posedge i_clk);
            end
            res_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!res_ch.valid) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        logic [127:0] got, want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            got = {res_ch.result_high, res_ch.result_low};
            if (result_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", got);
            end else begin
                want = result_q.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %h actual %h", want, got);
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((op_ch.valid && op_ch.ready) || (res_ch.valid && res_ch.ready) ||
            (op_ch.valid == 1'b0 && result_q.size() == 0))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("barrett_modular_multiply_core_tb failed");
            $finish;
        end
    end

    initial begin
        t_op_row rows[$];
        logic [127:0] p;
        int n;
        op_ch.valid = 1'b0;
        op_ch.cmd = bmm_pkg::CMD_MUL;
        op_ch.a_low = '0; op_ch.a_high = '0; op_ch.b_low = '0; op_ch.b_high = '0;
        sh_nbits = bmm_pkg::NBITS_RESET; sh_prime = '0; sh_mu = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // after reset p and mu are zero: products pass through unreduced
        rows.push_back('{bmm_pkg::CMD_MUL, 128'd3, 128'd5, 1'b1, 128'd15});
        rows.push_back('{bmm_pkg::CMD_SUB, 128'd9, 128'd4, 1'b1, 128'd5});
        rows.push_back('{bmm_pkg::CMD_SUB, 128'd4, 128'd9, 1'b1, {128{1'b1}} - 128'd4});
        rows.push_back('{bmm_pkg::CMD_SUB | bmm_pkg::CMD_SQR, 128'd7, 128'd2, 1'b1,
                         128'd5});
        rows.push_back('{bmm_pkg::CMD_SQR, {128{1'b1}}, 128'd0, 1'b0, 128'd0});
        rows.push_back('{bmm_pkg::CMD_MUL, {128{1'b1}}, {128{1'b1}}, 1'b0, 128'd0});
        foreach (rows[i]) begin
            send_op(rows[i].cmd, rows[i].a, rows[i].b, 1'b0);
            if (rows[i].has_exp && result_q[$] !== rows[i].exp) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("table row %0d: expected %h actual %h", i, rows[i].exp,
                             result_q[$]);
            end
        end
        drain();

        // largest 128-bit field
        p = {128{1'b1}} - 128'd158;
        set_field(128, p);
        rows.delete();
        rows.push_back('{bmm_pkg::CMD_MUL, p - 1, p - 1, 1'b1, 128'd1});
        rows.push_back('{bmm_pkg::CMD_SQR, p - 1, 128'd0, 1'b1, 128'd1});
        rows.push_back('{bmm_pkg::CMD_SUB, 128'd0, 128'd1, 1'b1, p - 1});
        rows.push_back('{bmm_pkg::CMD_SUB, 128'd0, 128'd0, 1'b1, 128'd0});
        rows.push_back('{bmm_pkg::CMD_MUL, 128'd0, p - 1, 1'b1, 128'd0});
        rows.push_back('{bmm_pkg::CMD_MUL, rand128() % p, rand128() % p, 1'b0, 128'd0});
        rows.push_back('{bmm_pkg::CMD_SUB | bmm_pkg::CMD_SQR, p - 1, 128'd0, 1'b1, p - 1});
        foreach (rows[i]) begin
            send_op(rows[i].cmd, rows[i].a, rows[i].b, 1'b0);
            if (rows[i].has_exp && result_q[$] !== rows[i].exp) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("table row %0d: expected %h actual %h", i, rows[i].exp,
                             result_q[$]);
            end
        end
        drain();

        // smallest and out-of-range widths
        set_field(2, 128'd3);
        send_op(bmm_pkg::CMD_MUL, 128'd2, 128'd2, 1'b0);
        send_op(bmm_pkg::CMD_SUB, 128'd0, 128'd2, 1'b0);
        send_op(bmm_pkg::CMD_SQR, {128{1'b1}}, 128'd0, 1'b0);
        drain();
        cfg_write(bmm_pkg::CFG_NBITS, 64'd0);
        send_op(bmm_pkg::CMD_MUL, 128'd2, 128'd1, 1'b0);
        drain();
        cfg_write(bmm_pkg::CFG_NBITS, 64'd255);
        send_op(bmm_pkg::CMD_MUL, 128'd2, 128'd2, 1'b0);
        drain();

        // random phases, each with a new field
        for (int ph = 0; ph < 16; ph++) begin
            case (ph % 4)
                0: n = 128;
                1: n = $urandom_range(2, 16);
                default: n = $urandom_range(2, 128);
            endcase
            p = rand128();
            if (n < 128) p = p & ((128'd1 << n) - 1);
            p[n - 1] = 1'b1;
            if (ph == 5) p = (n < 128) ? ((128'd1 << n) - 1) : {128{1'b1}};
            set_field(n, p);
            if (ph == 7) cfg_write(bmm_pkg::CFG_MU_TOP, 64'(~sh_mu[129:128])); // garbage mu
            for (int k = 0; k < 105; k++) begin
                if (ph == 3 && k == 10) rx_hold = 1'b1;
                if (ph == 3 && k == 60) rx_hold = 1'b0;
                send_op((bmm_pkg::CMD_W)'($urandom_range(0, 3)), below_p(), below_p(),
                        ph != 9);
                if (ph == 3 && k == 80) drain();
            end
            drain();
        end

        if (mismatches == 0 && result_q.size() == 0)
            $display("barrett_modular_multiply_core_tb passed");
        else
            $display("barrett_modular_multiply_core_tb failed");
        $finish;
    end

    // hold-off stretch runs in its own process
    initial begin
        wait (rx_hold);
        repeat (200) @(posedge i_clk);
        rx_hold = 1'b0;
    end
endmodule
